// ===== sv/gev_pkg.sv =====
package gev_pkg;

  // exp table geometry, depth is a power of two from 32 to 4096
  localparam int EXP_TABLE_DEPTH = 256;
  localparam int EXP_IDX_W       = $clog2(EXP_TABLE_DEPTH);
  localparam int POS_W           = 32 + EXP_IDX_W;

  // datapath widths
  localparam int DIFF_W = 33;   // pos - mean
  localparam int PROD_W = 49;   // Q2.14 times difference
  localparam int SUM_W  = 50;   // rotated sum, Q.30
  localparam int MAG_W  = 35;   // rotated magnitude, Q.16
  localparam int SCL_W  = 67;   // magnitude times reciprocal, Q.32
  localparam int U_W    = 28;   // scaled magnitude, Q.24, at most 8.0
  localparam int SQ_W   = 56;   // u squared, Q.48
  localparam int R2_W   = 37;   // r squared below 32, Q.32

  localparam logic [SCL_W-1:0] U_LIMIT = SCL_W'(1) << 35;

  typedef enum logic [2:0] {
    REG_DIM_MODE    = 3'd0,
    REG_MEAN_X      = 3'd1,
    REG_MEAN_Y      = 3'd2,
    REG_INV_SIGMA_X = 3'd3,
    REG_INV_SIGMA_Y = 3'd4,
    REG_COS_ANGLE   = 3'd5,
    REG_SIN_ANGLE   = 3'd6,
    REG_PEAK_SCALE  = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic               dim_mode;
    logic signed [31:0] mean_x;
    logic signed [31:0] mean_y;
    logic [31:0]        inv_sigma_x;
    logic [31:0]        inv_sigma_y;
    logic signed [15:0] cos_angle;
    logic signed [15:0] sin_angle;
    logic [31:0]        peak_scale;
  } gev_cfg_t;

  typedef struct packed {
    logic             valid;
    logic [MAG_W-1:0] mag_x;
    logic [MAG_W-1:0] mag_y;
  } gev_mag_t;

  typedef struct packed {
    logic            valid;
    logic            uf;
    logic [R2_W-1:0] r2;
  } gev_r2_t;

  typedef logic [31:0] exp_rom_t [0:EXP_TABLE_DEPTH];

  // shift and subtract long division, used only while the table is built
  function automatic logic [63:0] div_u64(logic [63:0] num, logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= 65'(den)) begin
        rem    = rem - 65'(den);
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // samples exp(-k*16/depth) in Q1.31, built from a series for one step
  // and then repeated Q.56 products
  function automatic exp_rom_t build_exp_rom();
    exp_rom_t     rom;
    logic [63:0]  term;
    logic [63:0]  eh;
    logic [63:0]  val;
    logic [127:0] wide;
    logic         neg;
    term = 64'd1 << 56;
    eh   = term;
    val  = term;
    neg  = 1'b1;
    for (int n = 1; n < 64; n++) begin
      if (term != 64'd0) begin
        term = div_u64(term * 64'd16, 64'(EXP_TABLE_DEPTH) * 64'(n));
        eh   = neg ? eh - term : eh + term;
        neg  = !neg;
      end
    end
    for (int k = 0; k <= EXP_TABLE_DEPTH; k++) begin
      rom[k] = 32'((val + (64'd1 << 24)) >> 25);
      wide   = 128'(val) * 128'(eh);
      val    = 64'(wide >> 56);
    end
    return rom;
  endfunction

  localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage

// ===== sv/gev_if.sv =====
interface gev_pos_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  modport source (output valid, output pos_x, output pos_y, input ready);
  modport sink   (input valid, input pos_x, input pos_y, output ready);
endinterface

interface gev_den_if;
  logic        valid;
  logic        ready;
  logic [31:0] density;
  logic        underflow;
  modport source (output valid, output density, output underflow, input ready);
  modport sink   (input valid, input density, input underflow, output ready);
endinterface

// ===== sv/gev_offset.sv =====
module gev_offset (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  gev_pkg::gev_cfg_t      cfg,
  input  logic                   in_valid,
  input  logic signed [31:0]     pos_x,
  input  logic signed [31:0]     pos_y,
  output gev_pkg::gev_mag_t      mag
);

  // stage a: offsets from the mean
  logic                              a_vld_r;
  logic signed [gev_pkg::DIFF_W-1:0] dx_r, dy_r;

  // stage b: rotation products
  logic                              b_vld_r;
  logic signed [gev_pkg::DIFF_W-1:0] b_dx_r;
  logic signed [gev_pkg::PROD_W-1:0] p_cx_r, p_sy_r, p_cy_r, p_sx_r;

  // stage c: magnitudes
  logic                              c_vld_r;
  logic [gev_pkg::MAG_W-1:0]         mx_r, my_r;

  logic signed [gev_pkg::SUM_W-1:0]  rx_sum, ry_sum;
  logic [gev_pkg::SUM_W-1:0]         rx_abs, ry_abs;
  logic [gev_pkg::DIFF_W-1:0]        dx_abs;
  logic [gev_pkg::MAG_W-1:0]         mx_nxt, my_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_valid;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r   <= gev_pkg::DIFF_W'(pos_x) - gev_pkg::DIFF_W'(cfg.mean_x);
      dy_r   <= gev_pkg::DIFF_W'(pos_y) - gev_pkg::DIFF_W'(cfg.mean_y);
      b_dx_r <= dx_r;
      p_cx_r <= gev_pkg::PROD_W'(cfg.cos_angle) * gev_pkg::PROD_W'(dx_r);
      p_sy_r <= gev_pkg::PROD_W'(cfg.sin_angle) * gev_pkg::PROD_W'(dy_r);
      p_cy_r <= gev_pkg::PROD_W'(cfg.cos_angle) * gev_pkg::PROD_W'(dy_r);
      p_sx_r <= gev_pkg::PROD_W'(cfg.sin_angle) * gev_pkg::PROD_W'(dx_r);
      mx_r   <= mx_nxt;
      my_r   <= my_nxt;
    end
  end

  always_comb begin
    rx_sum = gev_pkg::SUM_W'(p_cx_r) + gev_pkg::SUM_W'(p_sy_r);
    ry_sum = gev_pkg::SUM_W'(p_cy_r) - gev_pkg::SUM_W'(p_sx_r);
    rx_abs = rx_sum[gev_pkg::SUM_W-1] ? gev_pkg::SUM_W'(-rx_sum) : gev_pkg::SUM_W'(rx_sum);
    ry_abs = ry_sum[gev_pkg::SUM_W-1] ? gev_pkg::SUM_W'(-ry_sum) : gev_pkg::SUM_W'(ry_sum);
    dx_abs = b_dx_r[gev_pkg::DIFF_W-1] ? gev_pkg::DIFF_W'(-b_dx_r)
                                       : gev_pkg::DIFF_W'(b_dx_r);
    if (cfg.dim_mode) begin
      // drop the 14 fraction bits of the angle, toward zero
      mx_nxt = rx_abs[gev_pkg::MAG_W+13:14];
      my_nxt = ry_abs[gev_pkg::MAG_W+13:14];
    end else begin
      mx_nxt = gev_pkg::MAG_W'(dx_abs);
      my_nxt = '0;
    end
  end

  assign mag.valid = c_vld_r;
  assign mag.mag_x = mx_r;
  assign mag.mag_y = my_r;

endmodule

// ===== sv/gev_scale.sv =====
module gev_scale (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  gev_pkg::gev_cfg_t cfg,
  input  gev_pkg::gev_mag_t mag,
  output gev_pkg::gev_r2_t  r2
);

  // stage d: split products magnitude * reciprocal
  logic        d_vld_r;
  logic [63:0] lo_x_r, lo_y_r;
  logic [34:0] hi_x_r, hi_y_r;

  // stage e: saturated scaled magnitudes
  logic                     e_vld_r;
  logic [gev_pkg::U_W-1:0]  ux_r, uy_r;

  // stage f: squares
  logic                     f_vld_r;
  logic [gev_pkg::SQ_W-1:0] sqx_r, sqy_r;

  // stage g: r squared and underflow
  logic                     g_vld_r;
  logic                     uf_r;
  logic [gev_pkg::R2_W-1:0] r2_r;

  logic [gev_pkg::SCL_W-1:0] sx_full, sy_full, sx_sat, sy_sat;
  logic [gev_pkg::SQ_W:0]    sq_sum;
  logic [gev_pkg::SQ_W-16:0] r2_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
      e_vld_r <= 1'b0;
      f_vld_r <= 1'b0;
      g_vld_r <= 1'b0;
    end else if (en) begin
      d_vld_r <= mag.valid;
      e_vld_r <= d_vld_r;
      f_vld_r <= e_vld_r;
      g_vld_r <= f_vld_r;
    end
  end

  always_comb begin
    sx_full = gev_pkg::SCL_W'(lo_x_r) + (gev_pkg::SCL_W'(hi_x_r) << 32);
    sy_full = gev_pkg::SCL_W'(lo_y_r) + (gev_pkg::SCL_W'(hi_y_r) << 32);
    // beyond 8.0 the point is far out in the tail anyway
    sx_sat  = (sx_full > gev_pkg::U_LIMIT) ? gev_pkg::U_LIMIT : sx_full;
    sy_sat  = (sy_full > gev_pkg::U_LIMIT) ? gev_pkg::U_LIMIT : sy_full;
    sq_sum  = (gev_pkg::SQ_W+1)'(sqx_r) + (gev_pkg::SQ_W+1)'(sqy_r);
    r2_full = sq_sum[gev_pkg::SQ_W:16];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lo_x_r <= 64'(mag.mag_x[31:0]) * 64'(cfg.inv_sigma_x);
      lo_y_r <= 64'(mag.mag_y[31:0]) * 64'(cfg.inv_sigma_y);
      hi_x_r <= 35'(mag.mag_x[gev_pkg::MAG_W-1:32]) * 35'(cfg.inv_sigma_x);
      hi_y_r <= 35'(mag.mag_y[gev_pkg::MAG_W-1:32]) * 35'(cfg.inv_sigma_y);
      ux_r   <= sx_sat[gev_pkg::U_W+7:8];
      uy_r   <= cfg.dim_mode ? sy_sat[gev_pkg::U_W+7:8] : '0;
      sqx_r  <= gev_pkg::SQ_W'(ux_r) * gev_pkg::SQ_W'(ux_r);
      sqy_r  <= gev_pkg::SQ_W'(uy_r) * gev_pkg::SQ_W'(uy_r);
      uf_r   <= |r2_full[gev_pkg::SQ_W-16:gev_pkg::R2_W];
      r2_r   <= r2_full[gev_pkg::R2_W-1:0];
    end
  end

  assign r2.valid = g_vld_r;
  assign r2.uf    = uf_r;
  assign r2.r2    = r2_r;

endmodule

// ===== sv/gev_exp.sv =====
module gev_exp (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  gev_pkg::gev_cfg_t cfg,
  input  gev_pkg::gev_r2_t  r2,
  output logic              out_valid,
  output logic [31:0]       density,
  output logic              underflow
);

  // stage h: table samples around the position
  logic        h_vld_r, h_uf_r;
  logic [31:0] a_r, b_r, frac_r;

  // stage i: slope times fraction
  logic        i_vld_r, i_uf_r, i_down_r;
  logic [31:0] i_a_r, step_r;

  // stage j: interpolated sample
  logic        j_vld_r, j_uf_r;
  logic [31:0] v_r;

  // stage k: peak scaling
  logic        k_vld_r, k_uf_r;
  logic [63:0] dp_r;

  // stage l: result register
  logic        l_vld_r, l_uf_r;
  logic [31:0] den_r;

  logic [gev_pkg::POS_W-1:0]     pos;
  logic [gev_pkg::EXP_IDX_W:0]   idx_a, idx_b;
  logic                          down;
  logic [31:0]                   diff;
  logic [63:0]                   slope_prod;
  logic [64:0]                   dp_rnd;
  logic [33:0]                   den_wide;
  logic [31:0]                   den_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_vld_r <= 1'b0;
      i_vld_r <= 1'b0;
      j_vld_r <= 1'b0;
      k_vld_r <= 1'b0;
      l_vld_r <= 1'b0;
    end else if (en) begin
      h_vld_r <= r2.valid;
      i_vld_r <= h_vld_r;
      j_vld_r <= i_vld_r;
      k_vld_r <= j_vld_r;
      l_vld_r <= k_vld_r;
    end
  end

  always_comb begin
    // position in table steps, Q.32
    pos   = gev_pkg::POS_W'(r2.r2) << (gev_pkg::EXP_IDX_W - 5);
    idx_a = {1'b0, pos[gev_pkg::POS_W-1:32]};
    idx_b = idx_a + 1'b1;
    down       = a_r >= b_r;
    diff       = down ? a_r - b_r : b_r - a_r;
    slope_prod = 64'(diff) * 64'(frac_r);
    dp_rnd     = 65'(dp_r) + (65'd1 << 30);
    den_wide   = dp_rnd[64:31];
    if (k_uf_r) begin
      den_nxt = '0;
    end else if (|den_wide[33:32]) begin
      den_nxt = '1;
    end else begin
      den_nxt = den_wide[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_uf_r   <= r2.uf;
      a_r      <= gev_pkg::EXP_ROM[idx_a];
      b_r      <= gev_pkg::EXP_ROM[idx_b];
      frac_r   <= pos[31:0];
      i_uf_r   <= h_uf_r;
      i_down_r <= down;
      i_a_r    <= a_r;
      step_r   <= slope_prod[63:32];
      j_uf_r   <= i_uf_r;
      v_r      <= i_down_r ? i_a_r - step_r : i_a_r + step_r;
      k_uf_r   <= j_uf_r;
      dp_r     <= 64'(cfg.peak_scale) * 64'(v_r);
      l_uf_r   <= k_uf_r;
      den_r    <= den_nxt;
    end
  end

  assign out_valid = l_vld_r;
  assign density   = den_r;
  assign underflow = l_uf_r;

endmodule

// ===== sv/rotated_gaussian_evaluator_top.sv =====
// channel    dir  modport  payload                          transfer when
// in_pos     in   sink     pos_x s32 Q16.16, pos_y s32      valid & ready
// out_den    out  source   density u32 Q16.16, underflow 1  valid & ready
// cfg_*      in   -        cfg_idx 3, cfg_data 32           cfg_we
//
// one point per cycle sustained while out_den takes results
// the pipeline is twelve register stages: offset (3), scale and square (4),
// table interpolation and peak scaling (5), the last one being the result register
// synchronous active-low reset clears all stage valid bits and loads the
// register defaults; the exp table is a constant and needs no fill
// a stall on out_den freezes every stage together, so in_pos.ready falls only
// while a finished result waits untaken
module rotated_gaussian_evaluator_top (
  input  logic        clk,
  input  logic        rst_n,
  gev_pos_if.sink     in_pos,
  gev_den_if.source   out_den,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [31:0] cfg_data
);

  gev_pkg::gev_cfg_t cfg_r;
  gev_pkg::gev_mag_t mag;
  gev_pkg::gev_r2_t  r2;
  logic              en;

  // global advance: the whole pipe moves unless the result register is held
  assign en           = !out_den.valid || out_den.ready;
  assign in_pos.ready = en;

  // configuration registers; the user must write them only while the pipe is empty, the block does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dim_mode    <= 1'b0;
      cfg_r.mean_x      <= '0;
      cfg_r.mean_y      <= '0;
      cfg_r.inv_sigma_x <= 32'd65536;
      cfg_r.inv_sigma_y <= 32'd65536;
      cfg_r.cos_angle   <= 16'sd16384;
      cfg_r.sin_angle   <= '0;
      cfg_r.peak_scale  <= 32'd26145;
    end else if (cfg_we) begin
      case (gev_pkg::cfg_idx_t'(cfg_idx))
        gev_pkg::REG_DIM_MODE:    cfg_r.dim_mode    <= cfg_data[0];
        gev_pkg::REG_MEAN_X:      cfg_r.mean_x      <= cfg_data;
        gev_pkg::REG_MEAN_Y:      cfg_r.mean_y      <= cfg_data;
        gev_pkg::REG_INV_SIGMA_X: cfg_r.inv_sigma_x <= cfg_data;
        gev_pkg::REG_INV_SIGMA_Y: cfg_r.inv_sigma_y <= cfg_data;
        gev_pkg::REG_COS_ANGLE:   cfg_r.cos_angle   <= cfg_data[15:0];
        gev_pkg::REG_SIN_ANGLE:   cfg_r.sin_angle   <= cfg_data[15:0];
        gev_pkg::REG_PEAK_SCALE:  cfg_r.peak_scale  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // mean subtraction and rotation
  gev_offset u_offset (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .cfg      (cfg_r),
    .in_valid (in_pos.valid),
    .pos_x    (in_pos.pos_x),
    .pos_y    (in_pos.pos_y),
    .mag      (mag)
  );

  // reciprocal deviation scaling and r squared
  gev_scale u_scale (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .cfg   (cfg_r),
    .mag   (mag),
    .r2    (r2)
  );

  // exp lookup with interpolation, peak scaling, result register
  gev_exp u_exp (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .cfg       (cfg_r),
    .r2        (r2),
    .out_valid (out_den.valid),
    .density   (out_den.density),
    .underflow (out_den.underflow)
  );

endmodule

// ===== sim/tb_rotated_gaussian_evaluator_top.sv =====
`timescale 1ns / 100ps

import gev_pkg::*;

typedef struct packed {
  logic [31:0] density;
  logic        underflow;
} density_t;

// keeps a copy of the register file and the exp samples, predicts each point
class density_checker;
  logic [31:0] exp_lut [0:EXP_TABLE_DEPTH];
  gev_cfg_t    cfg;
  density_t    pending_density [$];
  int          mismatches;

  function new();
    build_exp_lut();
    cfg.dim_mode    = 1'b0;
    cfg.mean_x      = 32'sd0;
    cfg.mean_y      = 32'sd0;
    cfg.inv_sigma_x = 32'd65536;
    cfg.inv_sigma_y = 32'd65536;
    cfg.cos_angle   = 16'sd16384;
    cfg.sin_angle   = 16'sd0;
    cfg.peak_scale  = 32'd26145;
    mismatches      = 0;
  endfunction

  // exp(-k*16/depth) in Q1.31: series for one step, then repeated Q.56 products
  function void build_exp_lut();
    logic [63:0]  term;
    logic [63:0]  step;
    logic [63:0]  acc;
    logic [127:0] wide;
    bit           neg;
    int           n;
    term = 64'd1 << 56;
    step = term;
    acc  = term;
    neg  = 1'b1;
    n    = 1;
    while (n < 64 && term != 64'd0) begin
      term = (term * 64'd16) / (64'(EXP_TABLE_DEPTH) * 64'(n));
      step = neg ? step - term : step + term;
      neg  = !neg;
      n++;
    end
    for (int k = 0; k <= EXP_TABLE_DEPTH; k++) begin
      exp_lut[k] = 32'((acc + (64'd1 << 24)) >> 25);
      wide       = {64'd0, acc} * {64'd0, step};
      acc        = wide[119:56];
    end
  endfunction

  function void set_reg(cfg_idx_t idx, logic [31:0] data);
    case (idx)
      REG_DIM_MODE:    cfg.dim_mode    = data[0];
      REG_MEAN_X:      cfg.mean_x      = data;
      REG_MEAN_Y:      cfg.mean_y      = data;
      REG_INV_SIGMA_X: cfg.inv_sigma_x = data;
      REG_INV_SIGMA_Y: cfg.inv_sigma_y = data;
      REG_COS_ANGLE:   cfg.cos_angle   = data[15:0];
      REG_SIN_ANGLE:   cfg.sin_angle   = data[15:0];
      REG_PEAK_SCALE:  cfg.peak_scale  = data;
      default: ;
    endcase
  endfunction

  function logic [63:0] magnitude_of(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // |offset| times reciprocal, clipped at 8.0, returned as Q.24
  function logic [63:0] scale_axis(logic [63:0] mag, logic [31:0] inv);
    logic [63:0] lim;
    lim = 64'd1 << 35;
    if (inv != 32'd0 && mag > lim / 64'(inv))
      return lim >> 8;
    return (mag * 64'(inv)) >> 8;
  endfunction

  function density_t gaussian_density(logic [31:0] px, logic [31:0] py);
    longint      dx;
    longint      dy;
    longint      c;
    longint      s;
    logic [63:0] ux;
    logic [63:0] uy;
    logic [63:0] r2;
    logic [63:0] tpos;
    logic [63:0] frac;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] v;
    logic [63:0] d;
    int          k;
    density_t    res;
    dx = longint'($signed(px)) - longint'($signed(cfg.mean_x));
    dy = longint'($signed(py)) - longint'($signed(cfg.mean_y));
    if (cfg.dim_mode) begin
      c  = $signed(cfg.cos_angle);
      s  = $signed(cfg.sin_angle);
      ux = scale_axis(magnitude_of(c * dx + s * dy) >> 14, cfg.inv_sigma_x);
      uy = scale_axis(magnitude_of(c * dy - s * dx) >> 14, cfg.inv_sigma_y);
    end else begin
      ux = scale_axis(magnitude_of(dx), cfg.inv_sigma_x);
      uy = 64'd0;
    end
    r2 = (ux * ux + uy * uy) >> 16;
    if (r2 >= (64'd32 << 32)) begin
      res.density   = 32'd0;
      res.underflow = 1'b1;
      return res;
    end
    tpos = (r2 * 64'(EXP_TABLE_DEPTH)) >> 5;
    k    = int'(tpos >> 32);
    if (k >= EXP_TABLE_DEPTH)
      k = EXP_TABLE_DEPTH - 1;
    frac = tpos & 64'hFFFF_FFFF;
    a    = 64'(exp_lut[k]);
    b    = 64'(exp_lut[k + 1]);
    v    = (a >= b) ? a - (((a - b) * frac) >> 32) : a + (((b - a) * frac) >> 32);
    d    = (64'(cfg.peak_scale) * v + (64'd1 << 30)) >> 31;
    if (d > 64'hFFFF_FFFF)
      d = 64'hFFFF_FFFF;
    res.density   = d[31:0];
    res.underflow = 1'b0;
    return res;
  endfunction

  function void note_point(logic [31:0] px, logic [31:0] py);
    pending_density.push_back(gaussian_density(px, py));
  endfunction

  function void check_density(logic [31:0] density, logic underflow);
    density_t want;
    if (pending_density.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: density %h underflow %b", density, underflow);
      return;
    end
    want = pending_density.pop_front();
    if (density !== want.density || underflow !== want.underflow) begin
      mismatches++;
      if (mismatches <= 10)
        $display("density mismatch: want %h/%b got %h/%b",
                 want.density, want.underflow, density, underflow);
    end
  endfunction
endclass

module tb_rotated_gaussian_evaluator_top;

  localparam int CYCLE_LIMIT = 200000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [31:0] cfg_data;
  bit          quiet;
  int          cycle_count;

  density_checker sb;

  gev_pos_if pos_if ();
  gev_den_if den_if ();

  rotated_gaussian_evaluator_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_pos   (pos_if),
    .out_den  (den_if),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  // 2 ns period
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // run guard, counts every rising edge
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("rotated_gaussian_evaluator_top test failed");
      $finish;
    end
  end

  // result side backpressure, changes on the falling edge
  always @(negedge clk) begin
    den_if.ready = quiet || ($urandom_range(0, 99) >= 26);
  end

  // input transfer: predict the density for that point
  always @(posedge clk) begin
    if (rst_n && pos_if.valid && pos_if.ready)
      sb.note_point(pos_if.pos_x, pos_if.pos_y);
  end

  // result transfer: compare with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && den_if.valid && den_if.ready)
      sb.check_density(den_if.density, den_if.underflow);
  end

  // called on a falling edge, returns on the falling edge after the transfer
  task automatic send_point(logic [31:0] px, logic [31:0] py);
    while (!quiet && $urandom_range(0, 99) < 26) begin
      pos_if.valid = 1'b0;
      pos_if.pos_x = $urandom();
      pos_if.pos_y = $urandom();
      @(negedge clk);
    end
    pos_if.valid = 1'b1;
    pos_if.pos_x = px;
    pos_if.pos_y = py;
    @(posedge clk);
    while (!pos_if.ready)
      @(posedge clk);
    @(negedge clk);
  endtask

  // register write, only issued while the pipeline is empty
  task automatic write_reg(cfg_idx_t idx, logic [31:0] data);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = data;
    sb.set_reg(idx, data);
    @(negedge clk);
    cfg_we   = 1'b0;
  endtask

  // every point gives one result, so an empty queue means an empty pipeline
  task automatic wait_idle();
    pos_if.valid = 1'b0;
    while (sb.pending_density.size() != 0)
      @(negedge clk);
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_mean(bit extreme);
    if (extreme)
      return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    if ($urandom_range(0, 3) == 0)
      return $urandom();
    return 32'(int'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
  endfunction

  // reciprocal deviations, normally sigma between 1/16 and 16
  function automatic logic [31:0] rand_inv(bit extreme);
    if (extreme) begin
      case ($urandom_range(0, 3))
        0:       return 32'd0;
        1:       return 32'hFFFF_FFFF;
        2:       return 32'd1;
        default: return $urandom();
      endcase
    end
    return $urandom_range(32'h0000_1000, 32'h0010_0000);
  endfunction

  // cos or sin with random upper bits on the data bus, which must be dropped
  function automatic logic [31:0] rand_trig(bit extreme);
    logic [15:0] t;
    if (extreme) begin
      case ($urandom_range(0, 4))
        0:       t = 16'h8000;
        1:       t = 16'h7FFF;
        2:       t = 16'h4000;
        3:       t = 16'hC000;
        default: t = 16'h0000;
      endcase
    end else begin
      t = 16'(int'($urandom_range(0, 32768)) - 16384);
    end
    return {16'($urandom()), t};
  endfunction

  // offset within about six deviations of the mean
  function automatic logic [31:0] near_offset(logic [31:0] inv);
    logic [63:0] span;
    span = (inv == 32'd0) ? (64'd1 << 20) : (64'd6 << 32) / 64'(inv);
    if (span > (64'd1 << 30))
      span = 64'd1 << 30;
    if (span == 64'd0)
      span = 64'd1;
    return 32'($urandom_range(0, 32'(2 * span))) - 32'(span);
  endfunction

  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = 3'd0;
    cfg_data     = 32'd0;
    quiet        = 1'b0;
    cycle_count  = 0;
    pos_if.valid = 1'b0;
    pos_if.pos_x = 32'd0;
    pos_if.pos_y = 32'd0;
    den_if.ready = 1'b0;
    sb = new();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset defaults, one-dimensional: center, unit steps, the r2 = 32 boundary,
    // the last table segment and offsets that clip the scaled magnitude
    send_point(32'h0000_0000, $urandom());
    send_point(32'h0001_0000, $urandom());
    send_point(32'hFFFF_0000, $urandom());
    send_point(32'd370727, $urandom());
    send_point(32'd370728, $urandom());
    send_point(32'(-370727), $urandom());
    send_point(32'd370700, $urandom());
    send_point(32'h7FFF_FFFF, 32'h8000_0000);
    send_point(32'h8000_0000, 32'h7FFF_FFFF);
    wait_idle();

    // rotated mode at 45 degrees with the largest peak
    write_reg(REG_DIM_MODE, 32'd1);
    write_reg(REG_MEAN_X, 32'h0001_2345);
    write_reg(REG_MEAN_Y, 32'hFFFE_0000);
    write_reg(REG_INV_SIGMA_X, 32'h0001_8000);
    write_reg(REG_INV_SIGMA_Y, 32'h0000_8000);
    write_reg(REG_COS_ANGLE, 32'd11585);
    write_reg(REG_SIN_ANGLE, 32'd11585);
    write_reg(REG_PEAK_SCALE, 32'hFFFF_FFFF);
    send_point(32'h0001_2345, 32'hFFFE_0000);
    send_point(32'h7FFF_FFFF, 32'h8000_0000);
    send_point(32'h8000_0000, 32'h7FFF_FFFF);
    send_point(32'h0003_2345, 32'hFFFE_8000);
    send_point(32'h0000_0000, 32'h0000_0000);
    wait_idle();

    // extreme means, zero and full reciprocals, unnormalized angle, zero peak
    write_reg(REG_MEAN_X, 32'h8000_0000);
    write_reg(REG_MEAN_Y, 32'h7FFF_FFFF);
    write_reg(REG_INV_SIGMA_X, 32'h0000_0000);
    write_reg(REG_INV_SIGMA_Y, 32'hFFFF_FFFF);
    write_reg(REG_COS_ANGLE, 32'hFFFF_8000);
    write_reg(REG_SIN_ANGLE, 32'h0000_7FFF);
    write_reg(REG_PEAK_SCALE, 32'h0000_0000);
    send_point(32'h8000_0000, 32'h7FFF_FFFF);
    send_point(32'h8000_0001, 32'h7FFF_FFFF);
    send_point(32'h7FFF_FFFF, 32'h8000_0000);
    wait_idle();

    // 90 degree rotation, tiny y reciprocal
    write_reg(REG_INV_SIGMA_Y, 32'd1);
    write_reg(REG_COS_ANGLE, 32'd0);
    write_reg(REG_SIN_ANGLE, 32'd16384);
    write_reg(REG_PEAK_SCALE, 32'h0001_0000);
    send_point(32'h8004_0000, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h7FFF_EFFF);
    wait_idle();

    // random phases, two with extreme registers, one with no idling at all
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_DIM_MODE, {31'($urandom()), 1'($urandom_range(0, 1))});
      write_reg(REG_MEAN_X, rand_mean(ph == 2 || ph == 5));
      write_reg(REG_MEAN_Y, rand_mean(ph == 2 || ph == 5));
      write_reg(REG_INV_SIGMA_X, rand_inv(ph == 2 || ph == 5));
      write_reg(REG_INV_SIGMA_Y, rand_inv(ph == 2 || ph == 5));
      write_reg(REG_COS_ANGLE, rand_trig(ph == 2 || ph == 5));
      write_reg(REG_SIN_ANGLE, rand_trig(ph == 2 || ph == 5));
      if (ph == 2 || ph == 5)
        write_reg(REG_PEAK_SCALE, $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0);
      else
        write_reg(REG_PEAK_SCALE, $urandom());
      quiet = (ph == 3);
      repeat (230) begin
        // mostly points near the center, the rest anywhere
        if ($urandom_range(0, 99) < 80)
          send_point(sb.cfg.mean_x + near_offset(sb.cfg.inv_sigma_x),
                     sb.cfg.mean_y + near_offset(sb.cfg.inv_sigma_y));
        else
          send_point($urandom(), $urandom());
      end
      wait_idle();
    end
    quiet = 1'b0;

    // let the pipeline run out and catch any stray result
    repeat (20) @(negedge clk);
    if (sb.pending_density.size() != 0)
      sb.mismatches++;
    if (sb.mismatches == 0)
      $display("rotated_gaussian_evaluator_top test passed");
    else
      $display("rotated_gaussian_evaluator_top test failed");
    $finish;
  end

endmodule

// ===== files.f =====
sv/gev_pkg.sv
sv/gev_if.sv
sv/gev_offset.sv
sv/gev_scale.sv
sv/gev_exp.sv
sv/rotated_gaussian_evaluator_top.sv
sim/tb_rotated_gaussian_evaluator_top.sv
